FILE: src/hsv_to_rgb_converter_assert.svh
// Assertion macros for the HSV to RGB converter.
// Uses no package; the including module supplies clock, reset and signal names.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSVRGB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold at every clock edge out of reset.
`define HSVRGB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

FILE: src/hsvrgb_pkg.sv
// Shared constants for the HSV to RGB converter.
// No dependencies.
package hsvrgb_pkg;

    localparam int HUE_WIDTH                 = 13;
    localparam int CHAN_WIDTH                = 8;
    localparam int COLOR_WIDTH               = 3 * CHAN_WIDTH;
    localparam int CHAN_MAX                  = 255;
    localparam int DEG_PERIOD                = 120;
    localparam int HUE_FRACTION_BITS_DEFAULT = 4;
    localparam int PIPE_LATENCY              = 8;

endpackage

FILE: src/hsvrgb_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Standalone; no package needed.
module hsvrgb_cdiv #(
    parameter int WIDTH   = 16,
    parameter int QWIDTH  = 8,
    parameter int DIVISOR = 3,
    localparam int RWIDTH = $clog2(DIVISOR)
) (
    input  logic              clk,
    input  logic [WIDTH-1:0]  din,
    output logic [QWIDTH-1:0] quot,
    output logic [RWIDTH-1:0] rem
);

    // floor(2^WIDTH / DIVISOR) undershoots the true quotient by at most one.
    localparam longint unsigned KVAL = (64'd1 << WIDTH) / DIVISOR;
    localparam int KWIDTH = $clog2(KVAL + 1);
    localparam int PWIDTH = WIDTH + KWIDTH;

    logic [PWIDTH-1:0] prod_reg, prod_next;
    logic [WIDTH-1:0]  din_reg;
    logic [QWIDTH-1:0] quot_reg, quot_next;
    logic [RWIDTH-1:0] rem_reg, rem_next;
    logic [QWIDTH-1:0] q0;
    logic [WIDTH-1:0]  r0;
    logic              corr;

    assign prod_next = PWIDTH'(din) * PWIDTH'(KVAL);

    always_comb
    begin
        q0        = QWIDTH'(prod_reg >> WIDTH);
        r0        = din_reg - WIDTH'(WIDTH'(q0) * WIDTH'(DIVISOR));
        corr      = (r0 >= WIDTH'(DIVISOR));
        quot_next = q0 + QWIDTH'(corr);
        rem_next  = corr ? RWIDTH'(r0 - WIDTH'(DIVISOR)) : RWIDTH'(r0);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        din_reg  <= din;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

FILE: src/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: an eight-stage pipeline.
// Depends on hsvrgb_pkg, hsvrgb_cdiv and hsv_to_rgb_converter_assert.svh.
//
//   Beat     Handshake       Payload
//   -------  --------------  ----------------------------------
//   input    start / busy    hue, saturation, brightness
//   output   done            color
//
// One pixel is taken every cycle; busy is always low.
// A pixel's color appears together with done at the end of the pipeline; the
// mixed channel is formed through the pipelined constant dividers.
// Reset clears only the valid bits that travel with each pixel.
// The receiver cannot stall, so the pipeline never holds.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter #(
    parameter int HUE_FRACTION_BITS = hsvrgb_pkg::HUE_FRACTION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hsvrgb_pkg::HUE_WIDTH-1:0]    hue,
    input  logic [hsvrgb_pkg::CHAN_WIDTH-1:0]   saturation,
    input  logic [hsvrgb_pkg::CHAN_WIDTH-1:0]   brightness,
    output logic                                done,
    output logic [hsvrgb_pkg::COLOR_WIDTH-1:0]  color
);

    import hsvrgb_pkg::*;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } sector_t;

    localparam longint UNIT      = 64'd1 << HUE_FRACTION_BITS;
    localparam longint PERIOD    = DEG_PERIOD * UNIT;
    localparam int     PERW      = $clog2(PERIOD + 1);
    localparam int     AW        = $clog2(CHAN_MAX * PERIOD + 1);
    localparam int     NW        = $clog2(CHAN_MAX * (2 * CHAN_MAX + 1) * PERIOD + 1);
    localparam int     YW        = $clog2(CHAN_MAX * (2 * CHAN_MAX + 1) * DEG_PERIOD + 1);
    localparam int     ZW        = $clog2(2 * CHAN_MAX * CHAN_MAX + CHAN_MAX + 1);
    localparam int     VNW       = 2 * CHAN_WIDTH;
    localparam int     HQW       = $clog2(((1 << HUE_WIDTH) - 1) / DEG_PERIOD + 1);
    localparam int     HRW       = $clog2(DEG_PERIOD);
    localparam int     M_DIV     = 2 * CHAN_MAX;
    localparam int     X_DIV     = 2 * CHAN_MAX * DEG_PERIOD;
    localparam longint SEC_LIM1  = 60 * UNIT;
    localparam longint SEC_LIM2  = 120 * UNIT;
    localparam longint SEC_LIM3  = 180 * UNIT;
    localparam longint SEC_LIM4  = 240 * UNIT;
    localparam longint SEC_LIM5  = 300 * UNIT;
    localparam logic [HUE_WIDTH-1:0] HUE_LOW_MASK = HUE_WIDTH'(UNIT - 1);

    logic [PIPE_LATENCY-1:0] valid_reg, valid_next;

    // Stage 0
    logic [CHAN_WIDTH-1:0] sat0_reg, bri0_reg;
    logic [HUE_WIDTH-1:0]  hue0_reg;
    sector_t               sec0_reg, sec0_next;
    logic [VNW-1:0]        vns0_reg, vns0_next;
    // Stage 1
    logic [CHAN_WIDTH-1:0] sat1_reg, bri1_reg;
    logic [HUE_WIDTH-1:0]  hue1_reg;
    sector_t               sec1_reg;
    // Stage 2
    logic [CHAN_WIDTH-1:0] sat2_reg, bri2_reg;
    sector_t               sec2_reg;
    logic [PERW-1:0]       dist2_reg, dist2_next;
    // Stage 3
    logic [CHAN_WIDTH-1:0] bri3_reg, m3_reg;
    sector_t               sec3_reg;
    logic [AW-1:0]         a3_reg, a3_next;
    // Stage 4
    logic [CHAN_WIDTH-1:0] bri4_reg, m4_reg;
    sector_t               sec4_reg;
    logic [YW-1:0]         y4_reg, y4_next;
    // Stages 5 and 6
    logic [CHAN_WIDTH-1:0] bri5_reg, m5_reg, bri6_reg, m6_reg;
    sector_t               sec5_reg, sec6_reg;
    // Output stage
    logic [COLOR_WIDTH-1:0] color_reg, color_next;

    logic [HQW-1:0]        hue_quot;
    logic [HRW-1:0]        hue_rem;
    logic [ZW-1:0]         m_num;
    logic [CHAN_WIDTH-1:0] m_quot, x_quot;
    logic [$clog2(M_DIV)-1:0] m_rem;
    logic [$clog2(X_DIV)-1:0] x_rem;
    logic [PERW-1:0]       rin;
    logic [PERW:0]         twice;
    logic [AW-1:0]         sd_prod;
    logic [NW-1:0]         va_sum;
    logic [CHAN_WIDTH-1:0] ch_r, ch_g, ch_b;

    assign busy       = 1'b0;
    assign valid_next = {valid_reg[PIPE_LATENCY-2:0], start};

    // Stage 0: sector choice and v*(1-s) product.
    always_comb
    begin
        vns0_next = VNW'(brightness) * VNW'(8'(CHAN_MAX) - saturation);
        priority if (longint'(hue) <= SEC_LIM1)
            sec0_next = SEC_RED_YEL;
        else if (longint'(hue) <= SEC_LIM2)
            sec0_next = SEC_YEL_GRN;
        else if (longint'(hue) <= SEC_LIM3)
            sec0_next = SEC_GRN_CYN;
        else if (longint'(hue) <= SEC_LIM4)
            sec0_next = SEC_CYN_BLU;
        else if (longint'(hue) <= SEC_LIM5)
            sec0_next = SEC_BLU_MAG;
        else
            sec0_next = SEC_MAG_RED;
    end

    // Whole degrees modulo 120; the fraction bits pass around the divider.
    hsvrgb_cdiv #(
        .WIDTH   (HUE_WIDTH),
        .QWIDTH  (HQW),
        .DIVISOR (DEG_PERIOD)
    ) u_hue_div (
        .clk  (clk),
        .din  (HUE_WIDTH'(hue >> HUE_FRACTION_BITS)),
        .quot (hue_quot),
        .rem  (hue_rem)
    );

    // m rounds v*(255-s)/255, computed as floor((2n + 255) / 510).
    assign m_num = ZW'({vns0_reg, 1'b0}) + ZW'(CHAN_MAX);

    hsvrgb_cdiv #(
        .WIDTH   (ZW),
        .QWIDTH  (CHAN_WIDTH),
        .DIVISOR (M_DIV)
    ) u_m_div (
        .clk  (clk),
        .din  (m_num),
        .quot (m_quot),
        .rem  (m_rem)
    );

    // Stage 1 to 2: twice the hue's distance from its 120 degree period's middle.
    always_comb
    begin
        rin        = PERW'((PERW'(hue_rem) << HUE_FRACTION_BITS)
                          | PERW'(hue1_reg & HUE_LOW_MASK));
        twice      = {rin, 1'b0};
        dist2_next = (twice >= (PERW+1)'(PERIOD)) ? PERW'(twice - (PERW+1)'(PERIOD))
                                                  : PERW'((PERW+1)'(PERIOD) - twice);
    end

    // Stage 2 to 3: s*t + (255-s)*P, which equals 255*P - s*dist.
    assign sd_prod = AW'(sat2_reg) * AW'(dist2_reg);
    assign a3_next = AW'(CHAN_MAX * PERIOD) - sd_prod;

    // Stage 3 to 4: rounding numerator; the power of two in P drops out by a shift.
    assign va_sum  = NW'((NW'(bri3_reg) * NW'(a3_reg)) << 1)
                     + NW'(CHAN_MAX * PERIOD);
    assign y4_next = YW'(va_sum >> HUE_FRACTION_BITS);

    hsvrgb_cdiv #(
        .WIDTH   (YW),
        .QWIDTH  (CHAN_WIDTH),
        .DIVISOR (X_DIV)
    ) u_x_div (
        .clk  (clk),
        .din  (y4_reg),
        .quot (x_quot),
        .rem  (x_rem)
    );

    // Stage 6 to output: route c+m, x+m and m to the channels.
    always_comb
    begin
        unique case (sec6_reg)
            SEC_RED_YEL:
            begin
                ch_r = bri6_reg; ch_g = x_quot;   ch_b = m6_reg;
            end
            SEC_YEL_GRN:
            begin
                ch_r = x_quot;   ch_g = bri6_reg; ch_b = m6_reg;
            end
            SEC_GRN_CYN:
            begin
                ch_r = m6_reg;   ch_g = bri6_reg; ch_b = x_quot;
            end
            SEC_CYN_BLU:
            begin
                ch_r = m6_reg;   ch_g = x_quot;   ch_b = bri6_reg;
            end
            SEC_BLU_MAG:
            begin
                ch_r = x_quot;   ch_g = m6_reg;   ch_b = bri6_reg;
            end
            default:
            begin
                ch_r = bri6_reg; ch_g = m6_reg;   ch_b = x_quot;
            end
        endcase
        color_next = {ch_r, ch_g, ch_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat0_reg  <= saturation;
        bri0_reg  <= brightness;
        hue0_reg  <= hue;
        sec0_reg  <= sec0_next;
        vns0_reg  <= vns0_next;

        sat1_reg  <= sat0_reg;
        bri1_reg  <= bri0_reg;
        hue1_reg  <= hue0_reg;
        sec1_reg  <= sec0_reg;

        sat2_reg  <= sat1_reg;
        bri2_reg  <= bri1_reg;
        sec2_reg  <= sec1_reg;
        dist2_reg <= dist2_next;

        bri3_reg  <= bri2_reg;
        sec3_reg  <= sec2_reg;
        a3_reg    <= a3_next;
        m3_reg    <= m_quot;

        bri4_reg  <= bri3_reg;
        sec4_reg  <= sec3_reg;
        m4_reg    <= m3_reg;
        y4_reg    <= y4_next;

        bri5_reg  <= bri4_reg;
        sec5_reg  <= sec4_reg;
        m5_reg    <= m4_reg;

        bri6_reg  <= bri5_reg;
        sec6_reg  <= sec5_reg;
        m6_reg    <= m5_reg;

        color_reg <= color_next;
    end

    assign done  = valid_reg[PIPE_LATENCY-1];
    assign color = color_reg;

    `HSVRGB_ASSERT_IMPLY(a_done_after_start, clk, rst_n, done,
        $past(start, PIPE_LATENCY), "done without a start beat eight cycles before")
    `HSVRGB_ASSERT_IMPLY(a_hue_rem_range, clk, rst_n, valid_reg[1],
        hue_rem < HRW'(DEG_PERIOD), "hue remainder not reduced below one period")
    `HSVRGB_ASSERT_IMPLY(a_channel_order, clk, rst_n, valid_reg[PIPE_LATENCY-2],
        (m6_reg <= bri6_reg) && (x_quot >= m6_reg) && (x_quot <= bri6_reg),
        "mixed channel outside the range from m to v")

endmodule

FILE: tb/hsv_to_rgb_converter_checker.sv
// Checker for the HSV to RGB converter: predicts each pixel's packed color and compares.
// Depends on hsvrgb_pkg; instantiated beside the block by tb_hsv_to_rgb_converter.
module hsv_to_rgb_converter_checker #(
    parameter int HUE_FRACTION_BITS = hsvrgb_pkg::HUE_FRACTION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [hsvrgb_pkg::HUE_WIDTH-1:0]    hue,
    input  logic [hsvrgb_pkg::CHAN_WIDTH-1:0]   saturation,
    input  logic [hsvrgb_pkg::CHAN_WIDTH-1:0]   brightness,
    input  logic                                done,
    input  logic [hsvrgb_pkg::COLOR_WIDTH-1:0]  color,
    output int                                  mismatches,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [COLOR_WIDTH-1:0] expected_colors[$];
    int                     mismatch_count = 0;

    // Rounds n/d to the nearest integer, ties upward.
    function automatic longint unsigned div_round(input longint unsigned num,
                                                  input longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic [COLOR_WIDTH-1:0] hsv_color(
        input logic [HUE_WIDTH-1:0]  h,
        input logic [CHAN_WIDTH-1:0] s,
        input logic [CHAN_WIDTH-1:0] v
    );
        longint unsigned deg_unit;
        longint unsigned period;
        longint unsigned half;
        longint unsigned hmod;
        longint unsigned spread;
        longint unsigned ramp;
        longint unsigned chroma;
        longint unsigned low;
        longint unsigned mixed;
        logic [CHAN_WIDTH-1:0] red;
        logic [CHAN_WIDTH-1:0] green;
        logic [CHAN_WIDTH-1:0] blue;

        deg_unit = longint'(1) << HUE_FRACTION_BITS;
        period   = DEG_PERIOD * deg_unit;
        half     = period / 2;
        hmod     = h % period;
        spread   = (2 * hmod >= period) ? 2 * hmod - period : period - 2 * hmod;
        ramp     = period - spread;

        chroma = 64'(v);
        low    = div_round(v * (CHAN_MAX - s), CHAN_MAX);
        mixed  = div_round(v * (s * ramp + (CHAN_MAX - s) * period), CHAN_MAX * period);

        // Hues on a sector boundary belong to the lower sector; anything past
        // the last boundary, including hues beyond a full turn, is in the top one.
        if (h <= half)
        begin
            red = CHAN_WIDTH'(chroma); green = CHAN_WIDTH'(mixed); blue = CHAN_WIDTH'(low);
        end
        else if (h <= 2 * half)
        begin
            red = CHAN_WIDTH'(mixed); green = CHAN_WIDTH'(chroma); blue = CHAN_WIDTH'(low);
        end
        else if (h <= 3 * half)
        begin
            red = CHAN_WIDTH'(low); green = CHAN_WIDTH'(chroma); blue = CHAN_WIDTH'(mixed);
        end
        else if (h <= 4 * half)
        begin
            red = CHAN_WIDTH'(low); green = CHAN_WIDTH'(mixed); blue = CHAN_WIDTH'(chroma);
        end
        else if (h <= 5 * half)
        begin
            red = CHAN_WIDTH'(mixed); green = CHAN_WIDTH'(low); blue = CHAN_WIDTH'(chroma);
        end
        else
        begin
            red = CHAN_WIDTH'(chroma); green = CHAN_WIDTH'(low); blue = CHAN_WIDTH'(mixed);
        end
        return {red, green, blue};
    endfunction

    always @(posedge clk)
    begin
        logic [COLOR_WIDTH-1:0] want;

        if (rst_n)
        begin
            if (done)
            begin
                if (expected_colors.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: color beat 0x%06h with no pixel outstanding",
                                 $realtime, color);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (color !== want)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: color mismatch, expected 0x%06h, got 0x%06h",
                                     $realtime, want, color);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                expected_colors.push_back(hsv_color(hue, saturation, brightness));
        end
        mismatches <= mismatch_count;
        pending    <= expected_colors.size();
    end

endmodule

FILE: tb/tb_hsv_to_rgb_converter.sv
// Testbench top for the HSV to RGB converter: drives pixels and gives the verdict.
// Depends on hsvrgb_pkg, hsv_to_rgb_converter and hsv_to_rgb_converter_checker.
module tb_hsv_to_rgb_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 1300;
    localparam int PHASES        = 3;
    localparam int HUE_STEP      = (DEG_PERIOD / 2) << HUE_FRACTION_BITS_DEFAULT;
    localparam int HUE_TURN      = 6 * HUE_STEP;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   start      = 1'b0;
    logic [HUE_WIDTH-1:0]   hue        = '0;
    logic [CHAN_WIDTH-1:0]  saturation = '0;
    logic [CHAN_WIDTH-1:0]  brightness = '0;
    logic                   busy;
    logic                   done;
    logic [COLOR_WIDTH-1:0] color;
    int                     mismatches;
    int                     pending;
    int                     quiet_cycles = 0;

    always #5 clk = ~clk;

    hsv_to_rgb_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .color      (color)
    );

    hsv_to_rgb_converter_checker color_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .color      (color),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Ends the run when neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("hsv_to_rgb_converter regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [HUE_WIDTH-1:0]  h,
                              input logic [CHAN_WIDTH-1:0] s,
                              input logic [CHAN_WIDTH-1:0] v,
                              input int                    idle_pct);
        bit taken;

        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        // Busy is stable between edges, so its value at the falling edge
        // decides whether the beat is taken at the next rising edge.
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
    endtask

    function automatic logic [CHAN_WIDTH-1:0] random_level();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [HUE_WIDTH-1:0] random_hue();
        unique case ($urandom_range(9))
            0:       return HUE_WIDTH'($urandom_range(2 ** HUE_WIDTH - 1, HUE_TURN));
            1:       return HUE_WIDTH'($urandom_range(6, 1) * HUE_STEP
                                       + $urandom_range(2) - 1);
            default: return HUE_WIDTH'($urandom_range(HUE_TURN - 1));
        endcase
    endfunction

    initial
    begin
        int idle_pct;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, a full and an empty pixel, and each sector boundary
        // with its neighbor above.
        send_pixel('0, '0, '0, 0);
        send_pixel('0, '1, '1, 0);
        send_pixel(HUE_WIDTH'(HUE_TURN - 1), '1, '1, 0);
        send_pixel('1, '1, '1, 0);
        send_pixel('1, '0, '1, 0);
        send_pixel(HUE_WIDTH'(HUE_TURN), 8'h80, 8'hC0, 0);
        send_pixel(HUE_WIDTH'(HUE_STEP / 2), '1, '1, 0);
        send_pixel(HUE_WIDTH'(HUE_STEP / 2), 8'h01, 8'h01, 0);
        for (int k = 1; k <= 5; k++)
        begin
            send_pixel(HUE_WIDTH'(k * HUE_STEP), '1, '1, 0);
            send_pixel(HUE_WIDTH'(k * HUE_STEP + 1), 8'hAA, 8'h55, 0);
        end
        send_pixel(13'h0AAA, 8'h55, 8'hAA, 0);
        send_pixel(13'h1555, 8'hAA, 8'h55, 0);

        // Sender idles rarely, then often, then never.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            idle_pct = (phase == 0) ? 11 : (phase == 1) ? 54 : 0;
            repeat (RANDOM_PIXELS / PHASES)
                send_pixel(random_hue(), random_level(), random_level(), idle_pct);
        end
        start <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("hsv_to_rgb_converter regression: pass");
        else
            $display("hsv_to_rgb_converter regression: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/hsvrgb_pkg.sv
src/hsvrgb_cdiv.sv
src/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_checker.sv
tb/tb_hsv_to_rgb_converter.sv
